// ===== rtl/core/ckr_pkg.sv =====
// Shared types and constants for the curve key reduction block.
// Used by the divider, datapath, controller and top level; no dependencies.
`timescale 1ns / 1ps

package ckr_pkg;

   localparam int VW           = 48;     // width of Q32.16 working values
   localparam int TOL_W        = 31;
   localparam logic [TOL_W-1:0] TOL_RESET = 31'd6554;
   localparam int MAX_KEYS_DEF = 65536;
   localparam int DIV_W        = 16;     // dividend / quotient width of the divider
   localparam int REM_W        = 33;     // remainder / divisor width of the divider
   localparam logic [5:0] ALPHA_STEPS = 6'd16;
   localparam logic [16:0] ALPHA_ONE  = 17'h10000;

   // reciprocals of three for 24-bit and 26-bit operands (shift 25 and 27)
   localparam logic [23:0] D3_M24 = 24'hAAAAAB;
   localparam logic [25:0] D3_M26 = 26'h2AAAAAB;

   localparam logic [1:0] MODE_CONST  = 2'd0;
   localparam logic [1:0] MODE_LINEAR = 2'd1;

   // alpha sources
   localparam logic [1:0] AL_ZERO = 2'd0;
   localparam logic [1:0] AL_FULL = 2'd1;
   localparam logic [1:0] AL_DIV  = 2'd2;

   // lerp operations
   localparam logic [2:0] LOP_01  = 3'd0;
   localparam logic [2:0] LOP_12  = 3'd1;
   localparam logic [2:0] LOP_23  = 3'd2;
   localparam logic [2:0] LOP_A   = 3'd3;
   localparam logic [2:0] LOP_B   = 3'd4;
   localparam logic [2:0] LOP_EST = 3'd5;
   localparam logic [2:0] LOP_LIN = 3'd6;

   // result kinds
   localparam logic [1:0] EMIT_NONE  = 2'd0;
   localparam logic [1:0] EMIT_FIRST = 2'd1;
   localparam logic [1:0] EMIT_PEND  = 2'd2;
   localparam logic [1:0] EMIT_LAST  = 2'd3;

   typedef struct packed {
      logic       setup;
      logic       est_kept;
      logic       al_we;
      logic [1:0] al_src;
      logic       div_start;
      logic       d3_hi;
      logic       d3_lo;
      logic       tmul;
      logic       tsel;
      logic       p_we;
      logic       lmul;
      logic       ladd;
      logic [2:0] lop;
      logic       dev;
      logic [1:0] emit;
      logic       advance;
   } ckr_cmd_type;

   typedef struct packed {
      logic first_done;
      logic pend_valid;
      logic is_last;
      logic span_pos;
      logic mode_const;
      logic mode_linear;
      logic num_le0;
      logic num_ge_span;
      logic div_busy;
      logic out_free;
   } ckr_status_type;

endpackage

// ===== rtl/core/ckr_divider.sv =====
// Restoring shift-subtract divider, one quotient bit per cycle.
// Depends on ckr_pkg for widths.
`timescale 1ns / 1ps

module ckr_divider import ckr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [REM_W-1:0] init_rem,
   input  logic [DIV_W-1:0] dividend,
   input  logic [REM_W-1:0] divisor,
   input  logic [5:0]       steps,
   output logic             busy,
   output logic [DIV_W-1:0] quotient
);

   logic [REM_W-1:0] rem_ff, rem_in, dsr_ff;
   logic [DIV_W-1:0] dvd_ff, dvd_in, quo_ff, quo_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [REM_W:0]   r2, diff;
   logic             ge;

   always_comb begin
      r2     = {rem_ff, dvd_ff[DIV_W-1]};
      diff   = r2 - {1'b0, dsr_ff};
      ge     = r2 >= {1'b0, dsr_ff};
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = init_rem;
         dvd_in  = dividend;
         quo_in  = '0;
         cnt_in  = steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[REM_W-1:0] : r2[REM_W-1:0];
         dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      if (start) dsr_ff <= divisor;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/ckr_datapath.sv =====
// Datapath: key registers, span and alpha, tangent offsets, lerp unit,
// deviation test and result register. Depends on ckr_pkg and ckr_divider.
`timescale 1ns / 1ps

module ckr_datapath import ckr_pkg::*; #(
   parameter int MAX_KEYS = MAX_KEYS_DEF,
   localparam int KCW = $clog2(MAX_KEYS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_accept,
   input  logic [127:0]     req_tdata,
   input  logic [3:0]       req_tuser,
   input  logic             req_tlast,
   input  logic             csr_valid,
   input  logic [TOL_W-1:0] csr_data,
   input  ckr_cmd_type      cmd,
   output ckr_status_type   st,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [23:0]      rsp_tdata,
   output logic             rsp_tlast
);

   logic [TOL_W-1:0] tol_ff;
   logic [KCW-1:0]   cnt_ff;
   logic             fd_ff, pv_ff;

   logic signed [31:0] cur_time_ff, cur_value_ff, cur_arr_ff, cur_leave_ff;
   logic [1:0]         cur_mode_ff;
   logic               cur_has_arr_ff, cur_has_leave_ff, cur_last_ff;

   logic signed [31:0] kept_time_ff, kept_value_ff, kept_leave_ff;
   logic [1:0]         kept_mode_ff;
   logic               kept_has_leave_ff;
   logic signed [31:0] pend_time_ff, pend_value_ff, pend_leave_ff;
   logic [1:0]         pend_mode_ff;
   logic               pend_has_leave_ff;

   logic signed [32:0] span_ff, num_ff;
   logic [16:0]        al_ff;
   logic signed [64:0] tprod_ff, tprod_in;
   logic [64:0]        tmag;
   logic signed [VW-1:0] off, p0, p3, p1_ff, p2_ff, p01_ff, p12_ff, p23_ff, est_ff;
   logic signed [VW-1:0] la, lb, lres;
   logic signed [VW:0]   ldiff;
   logic signed [66:0]   lprod_ff;
   logic signed [VW:0]   dev;
   logic [VW:0]          dev_abs;
   logic                 keep_ff;

   logic [47:0]      d3_hprod;
   logic [23:0]      d3_qh, d3_hrem, d3_qh_ff;
   logic [25:0]      d3_y_ff;
   logic [51:0]      d3_lprod;
   logic [47:0]      d3_q_ff;

   logic             div_busy;
   logic [DIV_W-1:0] div_q;

   logic             rsp_valid_ff, out_free;
   logic [15:0]      rsp_idx_ff;
   logic             rsp_keep_ff, rsp_last_ff;
   logic [KCW-1:0]   idx_sel;

   assign p0 = VW'(kept_value_ff);
   assign p3 = VW'(cur_value_ff);

   ckr_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .init_rem (num_ff[REM_W-1:0]),
      .dividend ('0),
      .divisor  (span_ff[REM_W-1:0]),
      .steps    (ALPHA_STEPS),
      .busy     (div_busy),
      .quotient (div_q)
   );

   always_comb begin
      tprod_in = (cmd.tsel ? cur_arr_ff : kept_leave_ff) * span_ff;
      tmag     = tprod_ff[64] ? -tprod_ff : tprod_ff;
      // |tprod| / 196608 as (|tprod| >> 16) / 3: upper 24 bits first, then
      // their remainder joined with the lower 24 bits
      d3_hprod = 48'(tmag[63:40]) * 48'(D3_M24);
      d3_qh    = {1'b0, d3_hprod[47:25]};
      d3_hrem  = tmag[63:40] - d3_qh - {d3_qh[22:0], 1'b0};
      d3_lprod = 52'(d3_y_ff) * 52'(D3_M26);
      off      = tprod_ff[64] ? -$signed(d3_q_ff) : $signed(d3_q_ff);
      case (cmd.lop)
         LOP_01:  begin la = p0;     lb = p1_ff;  end
         LOP_12:  begin la = p1_ff;  lb = p2_ff;  end
         LOP_23:  begin la = p2_ff;  lb = p3;     end
         LOP_A:   begin la = p01_ff; lb = p12_ff; end
         LOP_B:   begin la = p12_ff; lb = p23_ff; end
         LOP_EST: begin la = p01_ff; lb = p23_ff; end
         default: begin la = p0;     lb = p3;     end
      endcase
      ldiff   = (VW+1)'(lb) - (VW+1)'(la);
      lres    = la + $signed(lprod_ff[VW+15:16]);
      dev     = (VW+1)'(est_ff) - (VW+1)'(pend_value_ff);
      dev_abs = dev[VW] ? -dev : dev;
      out_free = !rsp_valid_ff || rsp_tready;
      idx_sel  = (cmd.emit == EMIT_PEND) ? cnt_ff - KCW'(1) : cnt_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff       <= TOL_RESET;
         cnt_ff       <= '0;
         fd_ff        <= 1'b0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) tol_ff <= csr_data;
         if (cmd.emit != EMIT_NONE) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         case (cmd.emit)
            EMIT_FIRST: begin
               if (cur_last_ff) begin
                  cnt_ff <= '0;
               end else begin
                  fd_ff  <= 1'b1;
                  cnt_ff <= cnt_ff + KCW'(1);
               end
            end
            EMIT_LAST: begin
               fd_ff  <= 1'b0;
               pv_ff  <= 1'b0;
               cnt_ff <= '0;
            end
            default: ;
         endcase
         if (cmd.advance) begin
            pv_ff  <= 1'b1;
            cnt_ff <= cnt_ff + KCW'(1);
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cur_time_ff      <= req_tdata[31:0];
         cur_value_ff     <= req_tdata[63:32];
         cur_arr_ff       <= req_tdata[95:64];
         cur_leave_ff     <= req_tdata[127:96];
         cur_mode_ff      <= req_tuser[1:0];
         cur_has_arr_ff   <= req_tuser[2];
         cur_has_leave_ff <= req_tuser[3];
         cur_last_ff      <= req_tlast || (cnt_ff >= KCW'(MAX_KEYS - 1));
      end
      if ((cmd.emit == EMIT_FIRST && !cur_last_ff)) begin
         kept_time_ff      <= cur_time_ff;
         kept_value_ff     <= cur_value_ff;
         kept_mode_ff      <= cur_mode_ff;
         kept_has_leave_ff <= cur_has_leave_ff;
         kept_leave_ff     <= cur_leave_ff;
      end else if (cmd.emit == EMIT_PEND && keep_ff) begin
         kept_time_ff      <= pend_time_ff;
         kept_value_ff     <= pend_value_ff;
         kept_mode_ff      <= pend_mode_ff;
         kept_has_leave_ff <= pend_has_leave_ff;
         kept_leave_ff     <= pend_leave_ff;
      end
      if (cmd.advance) begin
         pend_time_ff      <= cur_time_ff;
         pend_value_ff     <= cur_value_ff;
         pend_mode_ff      <= cur_mode_ff;
         pend_has_leave_ff <= cur_has_leave_ff;
         pend_leave_ff     <= cur_leave_ff;
      end
      if (cmd.setup) begin
         span_ff <= {cur_time_ff[31], cur_time_ff} - {kept_time_ff[31], kept_time_ff};
         num_ff  <= {pend_time_ff[31], pend_time_ff} - {kept_time_ff[31], kept_time_ff};
      end
      if (cmd.al_we) begin
         case (cmd.al_src)
            AL_ZERO: al_ff <= '0;
            AL_FULL: al_ff <= ALPHA_ONE;
            default: al_ff <= {1'b0, div_q[15:0]};
         endcase
      end
      if (cmd.tmul) tprod_ff <= tprod_in;
      if (cmd.d3_hi) begin
         d3_qh_ff <= d3_qh;
         d3_y_ff  <= {d3_hrem[1:0], tmag[39:16]};
      end
      if (cmd.d3_lo) d3_q_ff <= {d3_qh_ff, d3_lprod[50:27]};
      if (cmd.p_we) begin
         if (cmd.tsel) p2_ff <= cur_has_arr_ff ? p3 - off : p3;
         else          p1_ff <= kept_has_leave_ff ? p0 + off : p0;
      end
      if (cmd.lmul) lprod_ff <= ldiff * $signed({1'b0, al_ff});
      if (cmd.ladd) begin
         case (cmd.lop)
            LOP_01:  p01_ff <= lres;
            LOP_12:  p12_ff <= lres;
            LOP_23:  p23_ff <= lres;
            LOP_A:   p01_ff <= lres;
            LOP_B:   p23_ff <= lres;
            default: est_ff <= lres;
         endcase
      end
      if (cmd.est_kept) est_ff <= p0;
      if (cmd.dev) keep_ff <= dev_abs > (VW+1)'(tol_ff);
      if (cmd.emit != EMIT_NONE) begin
         rsp_idx_ff  <= 16'(idx_sel);
         rsp_keep_ff <= (cmd.emit == EMIT_PEND) ? keep_ff : 1'b1;
         rsp_last_ff <= (cmd.emit == EMIT_LAST) ||
                        (cmd.emit == EMIT_FIRST && cur_last_ff);
      end
   end

   always_comb begin
      st.first_done  = fd_ff;
      st.pend_valid  = pv_ff;
      st.is_last     = cur_last_ff;
      st.span_pos    = !span_ff[32] && (span_ff != '0);
      st.mode_const  = kept_mode_ff == MODE_CONST;
      st.mode_linear = kept_mode_ff == MODE_LINEAR;
      st.num_le0     = num_ff[32] || (num_ff == '0);
      st.num_ge_span = num_ff >= span_ff;
      st.div_busy    = div_busy;
      st.out_free    = out_free;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_keep_ff, rsp_idx_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/core/ckr_control.sv =====
// Controller: sequences one key through decode, alpha, tangents, lerps,
// deviation test and up to two results. Depends on ckr_pkg.
`timescale 1ns / 1ps

module ckr_control import ckr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_accept,
   input  ckr_status_type st,
   output logic           req_tready,
   output ckr_cmd_type    cmd
);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_DECODE = 5'd1;
   localparam logic [4:0] S_SETUP  = 5'd2;
   localparam logic [4:0] S_CHECK  = 5'd3;
   localparam logic [4:0] S_AWAIT  = 5'd4;
   localparam logic [4:0] S_MODE   = 5'd5;
   localparam logic [4:0] S_T1MUL  = 5'd6;
   localparam logic [4:0] S_T1HI   = 5'd7;
   localparam logic [4:0] S_T1LO   = 5'd8;
   localparam logic [4:0] S_T2MUL  = 5'd9;
   localparam logic [4:0] S_T2HI   = 5'd10;
   localparam logic [4:0] S_T2LO   = 5'd11;
   localparam logic [4:0] S_LMUL   = 5'd12;
   localparam logic [4:0] S_LADD   = 5'd13;
   localparam logic [4:0] S_DEV    = 5'd14;
   localparam logic [4:0] S_EMITP  = 5'd15;
   localparam logic [4:0] S_TAIL   = 5'd16;
   localparam logic [4:0] S_EMITF  = 5'd17;
   localparam logic [4:0] S_EMITL  = 5'd18;
   localparam logic [4:0] S_T1OFF  = 5'd19;
   localparam logic [4:0] S_T2OFF  = 5'd20;

   logic [4:0] state_ff, state_in;
   logic [2:0] lop_ff, lop_in;

   always_comb begin
      state_in = state_ff;
      lop_in   = lop_ff;
      cmd      = '0;
      cmd.lop  = lop_ff;
      unique case (state_ff)
         S_IDLE:   if (req_accept) state_in = S_DECODE;
         S_DECODE: begin
            if (!st.first_done)     state_in = S_EMITF;
            else if (st.pend_valid) state_in = S_SETUP;
            else                    state_in = S_TAIL;
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            if (!st.span_pos || st.mode_const) begin
               cmd.est_kept = 1'b1;
               state_in     = S_DEV;
            end else if (st.num_le0) begin
               cmd.al_we  = 1'b1;
               cmd.al_src = AL_ZERO;
               state_in   = S_MODE;
            end else if (st.num_ge_span) begin
               cmd.al_we  = 1'b1;
               cmd.al_src = AL_FULL;
               state_in   = S_MODE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_AWAIT;
            end
         end
         S_AWAIT: if (!st.div_busy) begin
            cmd.al_we  = 1'b1;
            cmd.al_src = AL_DIV;
            state_in   = S_MODE;
         end
         S_MODE: begin
            if (st.mode_linear) begin
               lop_in   = LOP_LIN;
               state_in = S_LMUL;
            end else begin
               lop_in   = LOP_01;
               state_in = S_T1MUL;
            end
         end
         S_T1MUL: begin
            cmd.tmul = 1'b1;
            state_in = S_T1HI;
         end
         S_T1HI: begin
            cmd.d3_hi = 1'b1;
            state_in  = S_T1LO;
         end
         S_T1LO: begin
            cmd.d3_lo = 1'b1;
            state_in  = S_T1OFF;
         end
         S_T1OFF: begin
            cmd.p_we = 1'b1;
            state_in = S_T2MUL;
         end
         S_T2MUL: begin
            cmd.tmul = 1'b1;
            cmd.tsel = 1'b1;
            state_in = S_T2HI;
         end
         S_T2HI: begin
            cmd.d3_hi = 1'b1;
            cmd.tsel  = 1'b1;
            state_in  = S_T2LO;
         end
         S_T2LO: begin
            cmd.d3_lo = 1'b1;
            cmd.tsel  = 1'b1;
            state_in  = S_T2OFF;
         end
         S_T2OFF: begin
            cmd.p_we = 1'b1;
            cmd.tsel = 1'b1;
            state_in = S_LMUL;
         end
         S_LMUL: begin
            cmd.lmul = 1'b1;
            state_in = S_LADD;
         end
         S_LADD: begin
            cmd.ladd = 1'b1;
            if (lop_ff == LOP_EST || lop_ff == LOP_LIN) begin
               state_in = S_DEV;
            end else begin
               lop_in   = lop_ff + 3'd1;
               state_in = S_LMUL;
            end
         end
         S_DEV: begin
            cmd.dev  = 1'b1;
            state_in = S_EMITP;
         end
         S_EMITP: if (st.out_free) begin
            cmd.emit = EMIT_PEND;
            state_in = S_TAIL;
         end
         S_TAIL: begin
            if (st.is_last) begin
               state_in = S_EMITL;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_EMITF: if (st.out_free) begin
            cmd.emit = EMIT_FIRST;
            state_in = S_IDLE;
         end
         S_EMITL: if (st.out_free) begin
            cmd.emit = EMIT_LAST;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         lop_ff   <= LOP_01;
      end else begin
         state_ff <= state_in;
         lop_ff   <= lop_in;
      end
   end

   assign req_tready = state_ff == S_IDLE;

endmodule

// ===== rtl/core/curve_key_reduction.sv =====
// Top level of the curve key reduction block: controller plus datapath.
// Depends on ckr_pkg, ckr_control and ckr_datapath.
`timescale 1ns / 1ps

// Keys of one curve stream in on req_, one beat per key, last key marked by
// req_tlast; one keep/drop beat per key leaves on rsp_ in key order. Keys are
// handled one at a time. The first key goes straight to its own result, and a
// key with no pending neighbor straight on to the next key. An interior
// decision skips alpha and the lerps for constant mode or a non-positive span;
// linear mode uses a 16-step serial alpha division (skipped when alpha clamps)
// and one lerp; cubic mode uses the alpha division, two tangent offsets
// (multiply, two reciprocal steps for the divide by three, add) and six lerps,
// each a multiply and an add. The last key adds its own beat after the decision.
// Output backpressure adds its own wait. The tolerance register is written
// on csr_ at any time and should only change between keys.

module curve_key_reduction import ckr_pkg::*; #(
   parameter int MAX_KEYS = MAX_KEYS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // [31:0] key_time, [63:32] key_value, [95:64] arrive_tangent,
   // [127:96] leave_tangent
   input  logic [127:0]     req_tdata,
   // [1:0] interp_mode, [2] has_arrive_tangent, [3] has_leave_tangent
   input  logic [3:0]       req_tuser,
   input  logic             req_tlast,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // [15:0] key_index, [16] keep, [23:17] zero
   output logic [23:0]      rsp_tdata,
   output logic             rsp_tlast,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [TOL_W-1:0] csr_data
);

   ckr_cmd_type    cmd;
   ckr_status_type st;
   logic           req_accept;

   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   ckr_control u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .st         (st),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   ckr_datapath #(.MAX_KEYS(MAX_KEYS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .st         (st),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_one_key: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("input accepted while a key is in work");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit != EMIT_NONE) |-> st.out_free)
      else $error("result loaded over an untaken result");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !st.div_busy)
      else $error("divider started while busy");

endmodule
